>>> rtl/q16alu_pkg.sv
// q16alu_pkg: command codes and constants for the q16.16 arithmetic unit
// no dependencies
`timescale 1ns / 1ps

package q16alu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int EXP_BIAS_SUM  = 150;
    localparam int CMD_W         = 4;
    localparam int DATA_W        = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD        = 4'd0,
        CMD_ADD_INT    = 4'd1,
        CMD_ADD_FLOAT  = 4'd2,
        CMD_SUB        = 4'd3,
        CMD_SUB_INT    = 4'd4,
        CMD_SUB_FLOAT  = 4'd5,
        CMD_MUL        = 4'd6,
        CMD_MUL_FLOAT  = 4'd7,
        CMD_MUL_INT    = 4'd8,
        CMD_DIV        = 4'd9,
        CMD_FROM_FLOAT = 4'd10,
        CMD_FROM_INT   = 4'd11,
        CMD_TO_INT     = 4'd12
    } cmd_t;

endpackage

>>> rtl/q16_16_arithmetic_unit.sv
// q16_16_arithmetic_unit: pipelined signed fixed point alu with a radix-2 divider
// depends on q16alu_pkg
`timescale 1ns / 1ps

// throughput: one transfer per cycle while the output is not stalled; the divider
// spends one pipeline stage per quotient bit (32 + FRAC_BITS stages), and every
// command travels the same path
// reset: aresetn low clears all stage valid bits; payload registers are not reset
// each stage holds when full and the stage after it is blocked, so a stalled
// output still lets earlier empty stages fill

module q16_16_arithmetic_unit #(
    parameter int FRAC_BITS = q16alu_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: operand_a [31:0], operand_b [63:32], float_operand [95:64]
    input  logic [95:0] s_tdata,
    // s_tuser: command [3:0]
    input  logic [3:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: result [31:0]
    output logic [31:0] m_tdata,
    // m_tuser: divide_by_zero [0]
    output logic [0:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready
);

    localparam int DW      = q16alu_pkg::DATA_W;
    // quotient magnitude width: |a| shifted up by the fraction bits
    localparam int QW      = DW + FRAC_BITS;
    localparam int LSH     = (FRAC_BITS + 1) / 2;
    localparam int RSH     = FRAC_BITS / 2;
    // stage map: capture, float convert + divide setup, add/operand select,
    // multiply, QW divide steps, final select
    localparam int DIV0    = 4;
    localparam int NS      = DIV0 + QW + 1;

    typedef struct packed {
        q16alu_pkg::cmd_t cmd;
        logic [DW-1:0]    a;
        logic [DW-1:0]    b;
        logic [DW-1:0]    c;
        logic [DW-1:0]    r;
        logic             dz;
        logic             neg;
        logic [DW-1:0]    dmag;
        logic [DW-1:0]    rem;
        logic [QW-1:0]    nq;
    } stage_t;

    stage_t        data_reg [NS];
    stage_t        data_next [NS];
    logic [NS-1:0] valid_reg;
    logic [NS:0]   ready;

    // ieee single bits to fixed point by shifting the mantissa
    function automatic logic [DW-1:0] float_to_fixed(input logic [DW-1:0] bits);
        logic signed [9:0] s;
        logic [9:0]        ns;
        logic [DW-1:0]     m;
        logic [DW-1:0]     v;
        m  = {8'd0, 1'b1, bits[22:0]};
        s  = 10'(q16alu_pkg::EXP_BIAS_SUM - FRAC_BITS) - $signed({2'b00, bits[30:23]});
        ns = -s;
        if (s > 0) begin
            v = (s >= 10'sd32) ? '0 : (m >> s[4:0]);
        end else if (s < 0) begin
            v = (ns >= 10'd32) ? '0 : (m << ns[4:0]);
        end else begin
            v = m;
        end
        if (bits[31]) begin
            v = -v;
        end
        return v;
    endfunction

    // ready ripples back from the output: a stage can take data when empty
    // or when its contents move on
    always_comb begin
        ready[NS] = m_tready;
        for (int k = NS - 1; k >= 0; k--) begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    assign s_tready = ready[0];

    always_comb begin
        stage_t           src;
        stage_t           nx;
        logic [DW-1:0]    amag;
        logic [DW-1:0]    t;
        logic             ge;
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                src = '0;
            end else begin
                src = data_reg[k-1];
            end
            nx   = src;
            amag = '0;
            t    = '0;
            ge   = 1'b0;
            if (k == 0) begin
                // capture the transfer
                nx.cmd = q16alu_pkg::cmd_t'(s_tuser);
                nx.a   = s_tdata[31:0];
                nx.b   = s_tdata[63:32];
                nx.c   = s_tdata[95:64];
            end else if (k == 1) begin
                // float conversion and divider operands
                nx.c    = float_to_fixed(src.c);
                nx.dz   = (src.cmd == q16alu_pkg::CMD_DIV) && (src.b == '0);
                nx.neg  = src.a[DW-1] ^ src.b[DW-1];
                amag    = src.a[DW-1] ? -src.a : src.a;
                nx.dmag = src.b[DW-1] ? -src.b : src.b;
                nx.nq   = {amag, {FRAC_BITS{1'b0}}};
                nx.rem  = '0;
            end else if (k == 2) begin
                // add/sub/convert results, multiplier operand select
                case (src.cmd)
                    q16alu_pkg::CMD_ADD:        nx.r = src.a + src.b;
                    q16alu_pkg::CMD_ADD_INT:    nx.r = src.a + (src.b << FRAC_BITS);
                    q16alu_pkg::CMD_ADD_FLOAT:  nx.r = src.a + src.c;
                    q16alu_pkg::CMD_SUB:        nx.r = src.a - src.b;
                    q16alu_pkg::CMD_SUB_INT:    nx.r = src.a - (src.b << FRAC_BITS);
                    q16alu_pkg::CMD_SUB_FLOAT:  nx.r = src.a - src.c;
                    q16alu_pkg::CMD_FROM_FLOAT: nx.r = src.c;
                    q16alu_pkg::CMD_FROM_INT:   nx.r = src.a << FRAC_BITS;
                    q16alu_pkg::CMD_TO_INT:     nx.r = DW'($signed(src.a) >>> FRAC_BITS);
                    default:                    nx.r = '0;
                endcase
                if (src.cmd == q16alu_pkg::CMD_MUL_INT) begin
                    nx.a = src.a;
                    nx.b = src.b;
                end else begin
                    nx.a = DW'($signed(src.a) >>> LSH);
                    if (src.cmd == q16alu_pkg::CMD_MUL_FLOAT) begin
                        nx.b = DW'($signed(src.c) >>> RSH);
                    end else begin
                        nx.b = DW'($signed(src.b) >>> RSH);
                    end
                end
            end else if (k == 3) begin
                // low word of the product is sign independent
                if (src.cmd == q16alu_pkg::CMD_MUL || src.cmd == q16alu_pkg::CMD_MUL_FLOAT
                        || src.cmd == q16alu_pkg::CMD_MUL_INT) begin
                    nx.r = DW'(src.a * src.b);
                end
            end else if (k < NS - 1) begin
                // one restoring divide step; remainder stays below the divisor
                t       = {src.rem[DW-2:0], src.nq[QW-1]};
                ge      = (t >= src.dmag);
                nx.rem  = ge ? (t - src.dmag) : t;
                nx.nq   = {src.nq[QW-2:0], ge};
            end else begin
                // signed quotient, wrapped; zero divisor forces zero
                if (src.cmd == q16alu_pkg::CMD_DIV) begin
                    if (src.dz) begin
                        nx.r = '0;
                    end else if (src.neg) begin
                        nx.r = -src.nq[DW-1:0];
                    end else begin
                        nx.r = src.nq[DW-1:0];
                    end
                end
            end
            data_next[k] = nx;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NS; k++) begin
            if (ready[k]) begin
                data_reg[k] <= data_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (ready[k]) begin
                    valid_reg[k] <= (k == 0) ? s_tvalid : valid_reg[k-1];
                end
            end
        end
    end

    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = data_reg[NS-1].r;
    assign m_tuser  = data_reg[NS-1].dz;

    // a flagged divide always delivers zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("divide by zero result not cleared");

    // divide by zero is only ever raised for the divide command
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> data_reg[NS-1].cmd == q16alu_pkg::CMD_DIV)
        else $error("divide by zero flag on non divide command");

    // an empty output stage means nothing downstream blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled with free output");

    // a stalled output holds its item in place
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(data_reg[NS-1].r))
        else $error("stalled output item changed");

endmodule
